FILE: rtl/mafs_pkg.sv
// ----------------------------------------------------------------------------
// MPEG audio frame sync parser: shared package
// Types, register indexes, result kinds and the bitrate and frame length ROMs.
// ----------------------------------------------------------------------------
package mafs_pkg;

    // Sync pattern
    localparam logic [7:0] SYNC_BYTE0 = 8'hFF;
    localparam logic [7:0] SYNC_MASK1 = 8'hE0;

    // Reset values of the configuration registers
    localparam logic [1:0] VERSION_RESET = 2'd3;
    localparam logic [1:0] LAYER_RESET   = 2'd1;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_VERSION = 1'b0,
        REG_LAYER   = 1'b1
    } reg_idx_t;

    // What an output item carries
    typedef enum logic
    {
        KIND_HEADER = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    // Frame length limits of a valid header
    localparam logic [10:0] FRAME_MIN    = 11'd96;
    localparam logic [10:0] FRAME_MAX    = 11'd1441;
    localparam logic [10:0] HEADER_BYTES = 11'd4;

    // Layer III bitrate table in kbit/s, index 0 and 15 are forbidden
    localparam logic [8:0] KBPS_ROM [16] = '{
        9'd0,   9'd32,  9'd40,  9'd48,  9'd56,  9'd64,  9'd80,  9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };

    // Frame length without padding, floor(144000 * kbps / rate)
    localparam logic [10:0] LEN_44K1 [16] = '{
        11'd0,   11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
        11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0
    };
    localparam logic [10:0] LEN_48K [16] = '{
        11'd0,   11'd96,  11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
        11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0
    };
    localparam logic [10:0] LEN_32K [16] = '{
        11'd0,   11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
        11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0
    };

    // Rate index codes
    localparam logic [1:0] RATE_44K1 = 2'd0;
    localparam logic [1:0] RATE_48K  = 2'd1;
    localparam logic [1:0] RATE_32K  = 2'd2;
    localparam logic [1:0] RATE_BAD  = 2'd3;

    // Configuration registers
    typedef struct packed
    {
        logic [1:0] wanted_version;
        logic [1:0] wanted_layer;
    } cfg_t;

    // Decoded header candidate
    typedef struct packed
    {
        logic        match;
        logic [1:0]  version_field;
        logic [1:0]  layer_field;
        logic [8:0]  bitrate_kbps;
        logic [1:0]  rate_index;
        logic        padding_flag;
        logic        crc_protected;
        logic [1:0]  chan_mode;
        logic [1:0]  mode_ext;
        logic [10:0] frame_bytes;
    } hdr_t;

    // Frame length lookup; zero for forbidden codes
    function automatic logic [10:0] frame_len(input logic [3:0] bri, input logic [1:0] rti);
        logic [10:0] len;
        begin
            unique case (rti)
                RATE_44K1: len = LEN_44K1[bri];
                RATE_48K:  len = LEN_48K[bri];
                RATE_32K:  len = LEN_32K[bri];
                default:   len = 11'd0;
            endcase
            return len;
        end
    endfunction

endpackage

FILE: rtl/mafs_cfg_regs.sv
// ----------------------------------------------------------------------------
// MPEG audio frame sync parser: configuration registers
// APB-style port holding the wanted version and layer fields.
// ----------------------------------------------------------------------------
module mafs_cfg_regs
    import mafs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[2]);
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wanted_version <= VERSION_RESET;
            cfg_reg.wanted_layer   <= LAYER_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_VERSION: cfg_reg.wanted_version <= pwdata[1:0];
                REG_LAYER:   cfg_reg.wanted_layer   <= pwdata[1:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_VERSION: prdata = {30'd0, cfg_reg.wanted_version};
            REG_LAYER:   prdata = {30'd0, cfg_reg.wanted_layer};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/mafs_hdr_decode.sv
// ----------------------------------------------------------------------------
// MPEG audio frame sync parser: header decode
// Checks the three window bytes for a wanted header and looks up its length.
// ----------------------------------------------------------------------------
module mafs_hdr_decode
    import mafs_pkg::*;
(
    input  logic [23:0] window,
    input  logic [7:0]  byte_in,
    input  cfg_t        cfg,
    output hdr_t        hdr
);

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [3:0]  bri;
    logic [1:0]  rti;
    logic [8:0]  kbps;
    logic [10:0] base_len;

    assign b0 = window[23:16];
    assign b1 = window[15:8];
    assign b2 = window[7:0];
    assign bri = b2[7:4];
    assign rti = b2[3:2];
    assign kbps = KBPS_ROM[bri];
    assign base_len = frame_len(bri, rti);

    // Field extraction and match
    always_comb
    begin
        hdr.version_field  = b1[4:3];
        hdr.layer_field    = b1[2:1];
        hdr.bitrate_kbps   = kbps;
        hdr.rate_index     = rti;
        hdr.padding_flag   = b2[1];
        hdr.crc_protected  = ~b1[0];
        hdr.chan_mode      = byte_in[7:6];
        hdr.mode_ext       = byte_in[5:4];
        hdr.frame_bytes    = base_len + {10'd0, b2[1]};
        hdr.match          = (b0 == SYNC_BYTE0)
                          && ((b1 & SYNC_MASK1) == SYNC_MASK1)
                          && (b1[4:3] == cfg.wanted_version)
                          && (b1[2:1] == cfg.wanted_layer)
                          && (kbps != 9'd0)
                          && (rti != RATE_BAD);
    end

endmodule

FILE: rtl/mpeg_audio_frame_sync_parser.sv
// ----------------------------------------------------------------------------
// MPEG audio frame sync parser: top level
// Hunts for frame headers in a byte stream and passes payload bytes as samples.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle and gives at most one item per
// byte: an accepted byte is held in the input register, then the parse stage
// updates the hunt state and loads the output register. While hunting it looks
// at the last three bytes plus the new one; a header that carries the sync, the
// configured version and layer and legal bitrate and rate codes yields a header
// item whose frame length comes from a constant ROM, then frame_bytes-4 sample
// items (byte minus 128) follow, after which hunting starts over with an empty
// window. The parse stage advances whenever the output register is empty or
// being taken, so a full byte rate is kept unless the output side stalls.
module mpeg_audio_frame_sync_parser
    import mafs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // stream input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] byte_in
    // stream output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,    // [7:0] sample, [9:8] version_field,
                                         // [11:10] layer_field, [20:12] bitrate_kbps,
                                         // [22:21] rate_index, [23] padding_flag,
                                         // [24] crc_protected, [26:25] chan_mode,
                                         // [28:27] mode_ext,
                                         // [39:29] frame_bytes, [71:40] frame_count
    output logic        m_axis_tuser,    // [0] result_kind
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    hdr_t  hdr;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parse state
    logic [23:0] window_reg,       window_next;
    logic [1:0]  fill_reg,         fill_next;
    logic        in_payload_reg,   in_payload_next;
    logic [10:0] payload_left_reg, payload_left_next;
    logic [31:0] frames_reg,       frames_next;

    // Output register
    logic        out_valid_reg;
    kind_t       out_kind_reg,     out_kind_next;
    logic [71:0] out_data_reg,     out_data_next;

    logic        out_free;
    logic        fire;
    logic        emit;
    logic [10:0] left_dec;

    mafs_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mafs_hdr_decode u_dec
    (
        .window  (window_reg),
        .byte_in (in_byte_reg),
        .cfg     (cfg),
        .hdr     (hdr)
    );

    // Handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    assign left_dec = (payload_left_reg != 11'd0) ? payload_left_reg - 11'd1 : 11'd0;

    // Parse step for the item in the input register
    always_comb
    begin
        window_next       = window_reg;
        fill_next         = fill_reg;
        in_payload_next   = in_payload_reg;
        payload_left_next = payload_left_reg;
        frames_next       = frames_reg;
        out_kind_next     = KIND_SAMPLE;
        out_data_next     = 72'd0;
        emit              = 1'b0;
        priority if (in_payload_reg)
        begin
            emit              = 1'b1;
            out_kind_next     = KIND_SAMPLE;
            out_data_next     = {64'd0, in_byte_reg ^ 8'h80};
            payload_left_next = left_dec;
            if (left_dec == 11'd0)
            begin
                in_payload_next = 1'b0;
                fill_next       = 2'd0;
                window_next     = 24'd0;
            end
        end
        else if (fill_reg != 2'd3)
        begin
            window_next = {window_reg[15:0], in_byte_reg};
            fill_next   = fill_reg + 2'd1;
        end
        else if (!hdr.match)
        begin
            window_next = {window_reg[15:0], in_byte_reg};
        end
        else
        begin
            emit              = 1'b1;
            frames_next       = frames_reg + 32'd1;
            out_kind_next     = KIND_HEADER;
            out_data_next     = {frames_next, hdr.frame_bytes, hdr.mode_ext,
                                 hdr.chan_mode, hdr.crc_protected, hdr.padding_flag,
                                 hdr.rate_index, hdr.bitrate_kbps, hdr.layer_field,
                                 hdr.version_field, 8'd0};
            window_next       = 24'd0;
            fill_next         = 2'd0;
            payload_left_next = hdr.frame_bytes - HEADER_BYTES;
            in_payload_next   = (payload_left_next != 11'd0);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            window_reg       <= 24'd0;
            fill_reg         <= 2'd0;
            in_payload_reg   <= 1'b0;
            payload_left_reg <= 11'd0;
            frames_reg       <= 32'd0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                window_reg       <= window_next;
                fill_reg         <= fill_next;
                in_payload_reg   <= in_payload_next;
                payload_left_reg <= payload_left_next;
                frames_reg       <= frames_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (fire && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
        end
    end

`ifndef ASSERT_OFF
    // A frame in progress always has bytes left to pass
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> payload_left_reg != 11'd0)
        else $error("payload state with no bytes left");

    // The window is empty throughout a frame's payload
    a_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (fill_reg == 2'd0) && (window_reg == 24'd0))
        else $error("window not empty during payload");

    // A header item carries a legal frame length and no sample
    a_header_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_HEADER)) |->
        (m_axis_tdata[39:29] >= FRAME_MIN) && (m_axis_tdata[39:29] <= FRAME_MAX)
        && (m_axis_tdata[7:0] == 8'd0))
        else $error("header item with bad frame length");

    // A sample item carries nothing but the sample
    a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_SAMPLE)) |-> m_axis_tdata[71:8] == 64'd0)
        else $error("sample item with header fields set");
`endif

endmodule
